### hdl/qpht_pkg.sv
// Package for the quadratic probe hash table: status codes, widths, defaults.
// No dependencies.
package qpht_pkg;

  localparam int unsigned DefTableDepth = 1024;
  localparam int unsigned KeyW          = 64;
  localparam int unsigned PosW          = 32;
  localparam int unsigned CntW          = 32;
  localparam int unsigned SizeW         = 11;
  localparam int unsigned SlotW         = 10;
  localparam int unsigned StatusW       = 3;

  localparam logic [StatusW-1:0] StNew     = 3'd0;
  localparam logic [StatusW-1:0] StUpdated = 3'd1;
  localparam logic [StatusW-1:0] StDropped = 3'd2;
  localparam logic [StatusW-1:0] StHit     = 3'd3;
  localparam logic [StatusW-1:0] StMiss    = 3'd4;

  localparam logic OpInsert = 1'b0;
  localparam logic OpLookup = 1'b1;

endpackage

### hdl/qpht_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module qpht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/quadratic_probe_hash_table_top.sv
// Quadratic probe hash table, top level: handshake, probe sequencer, clear sweep.
// Depends on qpht_pkg and qpht_ram.
//
//  channel | dir | fields (low bit up)
//  s_axis  | in  | tuser=op, tdata=key[63:0] position[95:64] occurrences[127:96]
//  m_axis  | out | tdata=status[2:0] slot[12:3] stored_position[44:13]
//          |     |       stored_count[76:45], zero to 80 bits
//  cfg     | in  | table_size, 11 bits, written when cfg_we_i is high
//
// Home slot: key mod size by a restoring reduction, one bit a cycle.
// Each probe is one entry read (address, then compare); the result is held
// in a pending register and moves to the output register once that is
// empty, and only then can the next request be taken. After reset a sweep
// over every entry clears the valid memory before the first request is
// taken. One item at a time; the output register holds a result while the
// next request is being worked.
module quadratic_probe_hash_table_top #(
  parameter int unsigned TableDepth = qpht_pkg::DefTableDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // key, position, occurrences
  input  logic         s_axis_tuser,  // op
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [79:0]  m_axis_tdata,  // status, slot, stored_position, stored_count
  input  logic         cfg_we_i,
  input  logic [10:0]  cfg_wdata_i
);

  localparam int unsigned AW = $clog2(TableDepth);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned EW = qpht_pkg::KeyW + qpht_pkg::PosW + qpht_pkg::CntW;

  localparam logic [2:0] SClear = 3'd0;
  localparam logic [2:0] SIdle  = 3'd1;
  localparam logic [2:0] SMod   = 3'd2;
  localparam logic [2:0] SRead  = 3'd3;
  localparam logic [2:0] SCmp   = 3'd4;
  localparam logic [2:0] SDone  = 3'd5;

  function automatic logic [qpht_pkg::SlotW-1:0] SlotWs(input logic [AW-1:0] a);
    return qpht_pkg::SlotW'(a);
  endfunction

  logic [2:0] state_q, state_d;
  logic [qpht_pkg::SizeW-1:0] size_cfg_q;
  logic [CW-1:0] size_q;      // effective size latched per item
  logic [CW-1:0] clr_q;
  logic op_q;
  logic [qpht_pkg::KeyW-1:0] key_q, shift_q;
  logic [qpht_pkg::PosW-1:0] pos_q;
  logic [qpht_pkg::CntW-1:0] occ_q;
  logic [6:0] bit_q;
  logic [CW:0] rem_q;         // remainder, then current slot
  logic [CW-1:0] idx_q;       // probe number i
  logic [CW:0] step_q;        // 2i+1, increment from i*i to (i+1)^2, mod size

  logic out_valid_q;
  logic [79:0] out_q;

  // effective size
  logic [CW-1:0] eff_size;
  always_comb begin
    eff_size = CW'(size_cfg_q);
    if (size_cfg_q < 11'd2) eff_size = CW'(2);
    if (32'(size_cfg_q) > TableDepth) eff_size = CW'(TableDepth);
  end

  // memories
  logic v_we, v_wd, v_rd, e_we;
  logic [AW-1:0] v_wa, rd_addr;
  logic [EW-1:0] e_wd, e_rd;

  qpht_ram #(.Width(1), .Depth(TableDepth)) u_valid (
    .clk_i, .we_i(v_we), .waddr_i(v_wa), .wdata_i(v_wd),
    .raddr_i(rd_addr), .rdata_o(v_rd)
  );
  qpht_ram #(.Width(EW), .Depth(TableDepth)) u_entry (
    .clk_i, .we_i(e_we), .waddr_i(rd_addr), .wdata_i(e_wd),
    .raddr_i(rd_addr), .rdata_o(e_rd)
  );

  assign rd_addr = rem_q[AW-1:0];

  logic [qpht_pkg::KeyW-1:0] e_key;
  logic [qpht_pkg::PosW-1:0] e_pos;
  logic [qpht_pkg::CntW-1:0] e_cnt, cnt_inc;
  assign e_key = e_rd[qpht_pkg::KeyW-1:0];
  assign e_pos = e_rd[qpht_pkg::KeyW +: qpht_pkg::PosW];
  assign e_cnt = e_rd[qpht_pkg::KeyW+qpht_pkg::PosW +: qpht_pkg::CntW];
  assign cnt_inc = (e_cnt == '1) ? e_cnt : e_cnt + 1'b1;

  logic [CW:0] rem_sh, next_slot, next_step;
  assign rem_sh = {rem_q[CW-1:0], shift_q[qpht_pkg::KeyW-1]};
  always_comb begin
    next_slot = rem_q + step_q;
    if (next_slot >= {1'b0, size_q}) next_slot = next_slot - {1'b0, size_q};
    next_step = step_q + (CW+1)'(2);
    if (next_step >= {1'b0, size_q}) next_step = next_step - {1'b0, size_q};
  end

  logic [79:0] res;
  logic        res_fire;
  logic        hit;
  assign hit = v_rd && (e_key == key_q);

  always_comb begin
    state_d = state_q;
    v_we = 1'b0; v_wa = rd_addr; v_wd = 1'b1;
    e_we = 1'b0; e_wd = {occ_q, pos_q, key_q};
    res = '0; res_fire = 1'b0;
    case (state_q)
      SClear: begin
        v_we = 1'b1; v_wa = clr_q[AW-1:0]; v_wd = 1'b0;
        if (clr_q == CW'(TableDepth - 1)) state_d = SIdle;
      end
      SIdle: if (s_axis_tvalid) state_d = SMod;
      SMod: if (bit_q == 7'd63) state_d = SRead;
      SRead: state_d = SCmp;
      SCmp: begin
        if (!v_rd) begin
          res_fire = 1'b1;
          if (op_q == qpht_pkg::OpInsert) begin
            v_we = 1'b1; e_we = 1'b1;
            res = {3'b0, occ_q, pos_q, SlotWs(rd_addr), qpht_pkg::StNew};
          end else begin
            res = {77'b0, qpht_pkg::StMiss};
          end
        end else if (hit) begin
          res_fire = 1'b1;
          if (op_q == qpht_pkg::OpInsert) begin
            e_we = 1'b1; e_wd = {cnt_inc, pos_q, key_q};
            res = {3'b0, cnt_inc, pos_q, SlotWs(rd_addr), qpht_pkg::StUpdated};
          end else begin
            res = {3'b0, e_cnt, e_pos, SlotWs(rd_addr), qpht_pkg::StHit};
          end
        end else if (idx_q == size_q - 1'b1) begin
          res_fire = 1'b1;
          res = {77'b0, (op_q == qpht_pkg::OpInsert) ? qpht_pkg::StDropped
                                                      : qpht_pkg::StMiss};
        end else begin
          state_d = SRead;
        end
        if (res_fire) state_d = SDone;
      end
      SDone: if (!out_valid_q) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  assign s_axis_tready = (state_q == SIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClear;
      clr_q       <= '0;
      size_cfg_q  <= 11'd1024;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == SClear) clr_q <= clr_q + 1'b1;
      if (cfg_we_i) size_cfg_q <= cfg_wdata_i;
      if (m_axis_tvalid && m_axis_tready) out_valid_q <= 1'b0;
      if (state_q == SDone && !out_valid_q) out_valid_q <= 1'b1;
    end
  end

  logic [79:0] pend_q;

  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && s_axis_tvalid) begin
      op_q    <= s_axis_tuser;
      key_q   <= s_axis_tdata[63:0];
      shift_q <= s_axis_tdata[63:0];
      pos_q   <= s_axis_tdata[95:64];
      occ_q   <= s_axis_tdata[127:96];
      size_q  <= eff_size;
      bit_q   <= '0;
      rem_q   <= '0;
      idx_q   <= '0;
      step_q  <= (CW+1)'(1);
    end
    if (state_q == SMod) begin
      rem_q   <= (rem_sh >= {1'b0, size_q}) ? rem_sh - {1'b0, size_q} : rem_sh;
      shift_q <= {shift_q[qpht_pkg::KeyW-2:0], 1'b0};
      bit_q   <= bit_q + 1'b1;
    end
    if (state_q == SCmp && state_d == SRead) begin
      rem_q  <= next_slot;
      step_q <= next_step;
      idx_q  <= idx_q + 1'b1;
    end
    if (res_fire) pend_q <= res;
    if (state_q == SDone && !out_valid_q) out_q <= pend_q;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

### verif/testbench.sv
// Testbench for quadratic_probe_hash_table_top: random and directed insert/lookup
// requests checked against an in-bench table model. Depends on qpht_pkg and quadratic_probe_hash_table_top.
module testbench;
  import qpht_pkg::*;

  // status in the lowest bits, as on the result bus
  typedef struct packed {
    logic [CntW-1:0]    cnt;
    logic [PosW-1:0]    pos;
    logic [SlotW-1:0]   slot;
    logic [StatusW-1:0] status;
  } probe_result_t;

  class probe_table_sb;
    bit              valid[DefTableDepth];
    logic [KeyW-1:0] keys[DefTableDepth];
    logic [PosW-1:0] posn[DefTableDepth];
    logic [CntW-1:0] cnts[DefTableDepth];
    int unsigned     size;
    probe_result_t   pending[$];
    int              errors;

    function new();
      size = DefTableDepth;
      errors = 0;
    endfunction

    function void set_size(logic [SizeW-1:0] v);
      size = v < 2 ? 2 : (v > DefTableDepth ? DefTableDepth : v);
    endfunction

    function void note_request(logic op, logic [KeyW-1:0] key, logic [PosW-1:0] p,
                               logic [CntW-1:0] c);
      probe_result_t r;
      longint unsigned home, t;
      bit done;
      home = key % size;
      done = 0;
      r = '0;
      for (longint unsigned i = 0; i < size && !done; i++) begin
        t = (home + i * i) % size;
        if (!valid[t]) begin
          done = 1;
          if (op == OpInsert) begin
            valid[t] = 1; keys[t] = key; posn[t] = p; cnts[t] = c;
            r = '{status: StNew, slot: t[SlotW-1:0], pos: p, cnt: c};
          end else r.status = StMiss;
        end else if (keys[t] == key) begin
          done = 1;
          if (op == OpInsert) begin
            posn[t] = p;
            if (cnts[t] != '1) cnts[t]++;
            r = '{status: StUpdated, slot: t[SlotW-1:0], pos: posn[t], cnt: cnts[t]};
          end else r = '{status: StHit, slot: t[SlotW-1:0], pos: posn[t], cnt: cnts[t]};
        end
      end
      if (!done) r.status = op == OpInsert ? StDropped : StMiss;
      pending.push_back(r);
    endfunction

    function void check_result(logic [79:0] d);
      probe_result_t e, a;
      a = d[76:0];
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[79:77] != 0 || a.status != e.status || a.slot != e.slot || a.pos != e.pos
          || a.cnt != e.cnt) begin
        $display("%0t: mismatch expected status %0d slot %0d pos %h cnt %h", $time,
                 e.status, e.slot, e.pos, e.cnt);
        $display("%0t:          actual   status %0d slot %0d pos %h cnt %h", $time,
                 a.status, a.slot, a.pos, a.cnt);
        errors++;
      end
    endfunction
  endclass

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [79:0]  m_axis_tdata;
  logic         cfg_we_i = 0;
  logic [10:0]  cfg_wdata_i = '0;

  probe_table_sb sb = new();
  int  send_idle = 0;  // percent
  int  recv_stall = 0; // percent
  bit  hold_off = 0;
  logic [KeyW-1:0] used_keys[$];

  always #1 clk_i = ~clk_i;

  quadratic_probe_hash_table_top DUT (.*);

  // receiver
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall);
  end

  // tvalid stays high after a request is taken until the next idle cycle or drain
  task automatic send_request(logic op, logic [KeyW-1:0] key, logic [PosW-1:0] p,
                              logic [CntW-1:0] c);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {c, p, key};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(op, key, p, c);
    if (op == OpInsert) used_keys.push_back(key);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_size(logic [SizeW-1:0] v);
    cfg_we_i <= 1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.set_size(v);
    used_keys.delete();
  endtask

  function automatic logic [KeyW-1:0] pick_key(int span);
    if (used_keys.size() > 0 && $urandom_range(1)) return used_keys[$urandom_range(
        used_keys.size() - 1)];
    if ($urandom_range(3) == 0) return {$urandom, $urandom};
    return KeyW'($urandom_range(span));
  endfunction

  task automatic random_phase(int n, int span);
    logic [CntW-1:0] c;
    repeat (n) begin
      c = $urandom_range(7) == 0 ? 32'hFFFF_FFFF - $urandom_range(1) : $urandom;
      send_request($urandom_range(2) == 0, pick_key(span), $urandom, c);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: extremes, saturation, miss, update, full table
    send_request(OpLookup, 64'd5, 32'd0, 32'd0);
    send_request(OpInsert, 64'd0, 32'h0, 32'h0);
    send_request(OpInsert, '1, '1, 32'hFFFF_FFFE);
    send_request(OpInsert, '1, 32'h1234, 32'd0);
    send_request(OpInsert, '1, 32'h5678, 32'd0);
    send_request(OpLookup, '1, 32'd0, 32'd0);
    send_request(OpLookup, 64'd0, '1, '1);
    send_request(OpInsert, 64'd1024, 32'hAAAA_5555, 32'h5555_AAAA);
    send_request(OpLookup, 64'd2048, 32'd0, 32'd0);
    drain();
    write_size(11'd0);
    send_request(OpLookup, '1, 32'd0, 32'd0);
    send_request(OpInsert, 64'd7, 32'd1, 32'd1);
    send_request(OpInsert, 64'd9, 32'd2, 32'd2);
    send_request(OpInsert, 64'd11, 32'd3, 32'd3);
    send_request(OpLookup, 64'd13, 32'd0, 32'd0);
    send_request(OpInsert, 64'd7, 32'd4, 32'd4);
    drain();
    write_size(11'h7FF);
    send_request(OpLookup, 64'd9, 32'd0, 32'd0);
    send_request(OpInsert, 64'd2047, 32'd5, 32'd5);
    drain();
    // random phases over sizes and idling modes
    send_idle = 0;  recv_stall = 0;  write_size(11'd5);    random_phase(150, 20);
    drain();
    send_idle = 75; recv_stall = 0;  write_size(11'd2);    random_phase(60, 8);
    drain();
    send_idle = 0;  recv_stall = 75; write_size(11'd37);   random_phase(250, 120);
    drain();
    send_idle = 6;  recv_stall = 6;  write_size(11'd1024); random_phase(300, 3000);
    drain();
    send_idle = 0;  recv_stall = 0;  write_size(11'd3);    random_phase(100, 12);
    drain();
    write_size(11'd16);
    fork
      begin
        hold_off = 1;
        repeat (600) @(posedge clk_i);
        hold_off = 0;
      end
      random_phase(30, 40);
    join
    drain();
    send_idle = 6; recv_stall = 6; write_size(11'd1);      random_phase(40, 10);
    drain();
    write_size(11'd200); random_phase(450, 400);
    drain();
    if (sb.errors == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

  initial begin
    #4000000;
    $display("testbench: errors");
    $finish;
  end
endmodule
